// ===== sv/software_timer_slot_table_unit_assert.svh =====
// Assertion macros used by the checker of the timer slot table.
`ifndef SOFTWARE_TIMER_SLOT_TABLE_UNIT_ASSERT_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define STT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/stt_pkg.sv =====
package stt_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int MAX_OUT        = 16;
   localparam int FIRE_W         = $clog2(MAX_OUT + 1);

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] KIND_CREATE = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_FIRE   = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_REMOVED   = 2'd0;
   localparam logic [1:0] STAT_NULL_KEY  = 2'd1;
   localparam logic [1:0] STAT_DUPLICATE = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        owner_key;
      logic [31:0]        interval_ms;
      logic signed [31:0] repeat_count;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [15:0] fired_key;
      logic [3:0]  slot_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        owner;
      logic [31:0]        period;
      logic [31:0]        expiry;
      logic signed [31:0] repeats;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // Per-slot verdict handed from the slot evaluator to the sequencer.
   typedef struct packed {
      logic           key_match;
      logic           fire;
      logic           retire;
      slot_entry_type entry_next;
   } slot_eval_type;

endpackage

// ===== sv/stt_ram.sv =====
module stt_ram #(
   parameter int WIDTH = stt_pkg::ENTRY_W,
   parameter int DEPTH = stt_pkg::SLOT_COUNT_DEF
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same entry is written in that cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/stt_slot_eval.sv =====
module stt_slot_eval (
   input  logic                   live,
   input  logic                   room,
   input  stt_pkg::req_type       item,
   input  stt_pkg::slot_entry_type entry,
   output stt_pkg::slot_eval_type verdict
);
   import stt_pkg::*;

   logic [31:0] elapsed;

   // Expired when now minus expiry is not negative as a signed number.
   assign elapsed = item.now_ms - entry.expiry;

   always_comb begin
      verdict.key_match = live && (entry.owner == item.owner_key);
      verdict.fire      = live && room && (item.operation == OP_TICK) && !elapsed[31];
      verdict.retire    = (entry.repeats == 32'sd1);

      verdict.entry_next        = entry;
      verdict.entry_next.expiry = entry.expiry + entry.period;
      if (entry.repeats > 32'sd1) begin
         verdict.entry_next.repeats = entry.repeats - 32'sd1;
      end
   end

endmodule

// ===== sv/software_timer_slot_table_unit.sv =====
// Software timer slot table. Each request word is a create, cancel or tick
// operation; every create and cancel answers with exactly one status word,
// and a tick answers with one fire word for each expired slot (at most
// sixteen, lowest slot first), or with nothing when no slot has expired.
// The final word caused by a request carries last. Operation code 3 is
// taken and dropped without any answer. The slot owner, period, expiry and
// remaining repeat count live in a single-port-read RAM; the per-slot valid
// flags are flip-flops that reset clears, so no clearing pass is needed.
// Every create, cancel and tick sweeps the RAM one slot per cycle while
// the sweep is not held, so such a request occupies the block while it
// takes the word, runs the read-modify-write sweep over every slot and
// posts the closing answer. Operation code 3 starts no sweep, and the
// block is back to idle as soon as the word has been taken.
// A tick also waits whenever a fire word is ready while the output register
// is still held by a stall, and the closing answer of any operation waits in
// the last step until the output register is free. The block takes the next
// request while the last answer of the previous one still sits in the output
// register. Expiry uses wrap-safe arithmetic: a slot fires when now minus
// expiry, taken as a signed 32-bit value, is not negative. A fired slot is
// freed when its repeat count is one, counts down when the count is above
// one, and repeats forever when it is zero or less.
module software_timer_slot_table_unit #(
   parameter int SLOT_COUNT = stt_pkg::SLOT_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stt_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stt_pkg::rsp_type rsp_word
);
   import stt_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   req_type                 item_ff, item_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [SLOT_COUNT-1:0]   valid_ff, valid_in;
   logic                    key_hit_ff, key_hit_in;
   logic [IDX_W-1:0]        key_idx_ff, key_idx_in;
   logic                    free_hit_ff, free_hit_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [FIRE_W-1:0]       fires_ff, fires_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [15:0]             pend_key_ff, pend_key_in;
   logic [3:0]              pend_slot_ff, pend_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_word_ff, rsp_word_in;

   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   slot_entry_type          ram_wr_entry;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]      ram_rd_data;
   slot_entry_type          cur_entry;
   slot_eval_type           verdict;

   logic                    accept;
   logic                    out_free;
   logic                    live;
   logic                    room;
   logic                    adv;
   logic [IDX_W+3:0]        cur_ext, key_ext, free_ext;

   // The output register can take a new word when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign cur_entry = slot_entry_type'(ram_rd_data);
   assign live      = valid_ff[idx_ff];
   assign room      = (fires_ff < FIRE_W'(MAX_OUT));

   // The answer field holds the low four bits of a slot number.
   assign cur_ext  = {4'b0000, idx_ff};
   assign key_ext  = {4'b0000, key_idx_ff};
   assign free_ext = {4'b0000, free_idx_ff};

   stt_slot_eval u_eval (
      .live    (live),
      .room    (room),
      .item    (item_ff),
      .entry   (cur_entry),
      .verdict (verdict)
   );

   stt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A new fire word can only leave the sweep when the previously held fire
   // word has somewhere to go; otherwise the sweep holds on the current slot.
   always_comb begin
      adv = 1'b1;
      if ((item_ff.operation == OP_TICK) && verdict.fire && pend_valid_ff && !out_free) begin
         adv = 1'b0;
      end
   end

   // The read address runs one slot ahead of the slot being evaluated. While
   // the sweep holds, the same slot is read again so its data stays in place.
   always_comb begin
      ram_rd_addr = '0;
      if (state_ff == S_SCAN) begin
         if (adv && (idx_ff != LAST_IDX)) begin
            ram_rd_addr = idx_ff + 1'b1;
         end else begin
            ram_rd_addr = idx_ff;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      key_hit_in    = key_hit_ff;
      key_idx_in    = key_idx_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      fires_in      = fires_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_word_in   = rsp_word_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_entry  = verdict.entry_next;

      // A word in the output register leaves once it is not stalled.
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in       = req_word;
               idx_in        = '0;
               key_hit_in    = 1'b0;
               free_hit_in   = 1'b0;
               fires_in      = '0;
               pend_valid_in = 1'b0;
               if (req_word.operation != OP_NONE) begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (adv) begin
               case (item_ff.operation)
                  OP_CREATE: begin
                     if (verdict.key_match) begin
                        key_hit_in = 1'b1;
                     end
                     if (!live && !free_hit_ff) begin
                        free_hit_in = 1'b1;
                        free_idx_in = idx_ff;
                     end
                  end
                  OP_CANCEL: begin
                     if (verdict.key_match && !key_hit_ff) begin
                        key_hit_in = 1'b1;
                        key_idx_in = idx_ff;
                     end
                  end
                  OP_TICK: begin
                     if (verdict.fire) begin
                        fires_in = fires_ff + 1'b1;
                        if (verdict.retire) begin
                           valid_in[idx_ff] = 1'b0;
                        end else begin
                           ram_wr_en = 1'b1;
                        end
                        // The earlier fire word is now known not to be the last.
                        if (pend_valid_ff) begin
                           rsp_valid_in           = 1'b1;
                           rsp_word_in.kind       = KIND_FIRE;
                           rsp_word_in.status     = STAT_OK;
                           rsp_word_in.fired_key  = pend_key_ff;
                           rsp_word_in.slot_index = pend_slot_ff;
                           rsp_word_in.last       = 1'b0;
                        end
                        pend_valid_in = 1'b1;
                        pend_key_in   = cur_entry.owner;
                        pend_slot_in  = cur_ext[3:0];
                     end
                  end
                  default: begin
                  end
               endcase

               if (idx_ff == LAST_IDX) begin
                  state_in = S_FINISH;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_FINISH: begin
            if ((item_ff.operation == OP_TICK) && !pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               state_in               = S_IDLE;
               rsp_valid_in           = 1'b1;
               rsp_word_in.fired_key  = item_ff.owner_key;
               rsp_word_in.slot_index = 4'd0;
               rsp_word_in.last       = 1'b1;
               case (item_ff.operation)
                  OP_CREATE: begin
                     rsp_word_in.kind = KIND_CREATE;
                     if (item_ff.owner_key == 16'd0) begin
                        rsp_word_in.status = STAT_NULL_KEY;
                     end else if (key_hit_ff) begin
                        rsp_word_in.status = STAT_DUPLICATE;
                     end else if (!free_hit_ff) begin
                        rsp_word_in.status = STAT_FULL;
                     end else begin
                        rsp_word_in.status     = STAT_OK;
                        rsp_word_in.slot_index = free_ext[3:0];
                        valid_in[free_idx_ff]  = 1'b1;
                        ram_wr_en              = 1'b1;
                        ram_wr_addr            = free_idx_ff;
                        ram_wr_entry.owner     = item_ff.owner_key;
                        ram_wr_entry.period    = item_ff.interval_ms;
                        ram_wr_entry.expiry    = item_ff.now_ms + item_ff.interval_ms;
                        ram_wr_entry.repeats   = item_ff.repeat_count;
                     end
                  end
                  OP_CANCEL: begin
                     rsp_word_in.kind = KIND_CANCEL;
                     if (item_ff.owner_key == 16'd0) begin
                        rsp_word_in.status = STAT_NULL_KEY;
                     end else if (!key_hit_ff) begin
                        rsp_word_in.status = STAT_NOT_FOUND;
                     end else begin
                        rsp_word_in.status     = STAT_REMOVED;
                        rsp_word_in.slot_index = key_ext[3:0];
                        valid_in[key_idx_ff]   = 1'b0;
                     end
                  end
                  default: begin
                     // Tick: the held fire word is the final one.
                     rsp_word_in.kind       = KIND_FIRE;
                     rsp_word_in.status     = STAT_OK;
                     rsp_word_in.fired_key  = pend_key_ff;
                     rsp_word_in.slot_index = pend_slot_ff;
                     pend_valid_in          = 1'b0;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         key_hit_ff    <= 1'b0;
         free_hit_ff   <= 1'b0;
         fires_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         key_hit_ff    <= key_hit_in;
         free_hit_ff   <= free_hit_in;
         fires_ff      <= fires_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      key_idx_ff   <= key_idx_in;
      free_idx_ff  <= free_idx_in;
      pend_key_ff  <= pend_key_in;
      pend_slot_ff <= pend_slot_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== sv/stt_checker.sv =====
`include "software_timer_slot_table_unit_assert.svh"

module stt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input stt_pkg::req_type req_word,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input stt_pkg::rsp_type rsp_word
);
   import stt_pkg::*;

   // A word held back by a stall must not change or vanish.
   `STT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled response word changed")

   // Any real operation occupies the table for at least the next cycle.
   `STT_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall && (req_word.operation != OP_NONE), req_stall, "request taken without entering the sweep")

   // Create and cancel answer with a single word, so it is always the last.
   `STT_ASSERT_IMPL(a_status_is_last, clock, reset, rsp_valid && ((rsp_word.kind == KIND_CREATE) || (rsp_word.kind == KIND_CANCEL)), rsp_word.last, "status word without last")

   // Fire words carry a zero status.
   `STT_ASSERT_IMPL(a_fire_status, clock, reset, rsp_valid && (rsp_word.kind == KIND_FIRE), rsp_word.status == STAT_OK, "fire word with nonzero status")

endmodule

bind software_timer_slot_table_unit stt_checker u_stt_checker (.*);

// ===== dv/software_timer_slot_table_unit_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the timer slot table. It keeps its own copy of
// the slot table, works out the answer words for every accepted request and
// compares each accepted answer with the oldest one still owed.
module software_timer_slot_table_unit_checker #(
   parameter int SLOTS = stt_pkg::SLOT_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  stt_pkg::req_type req_word,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  stt_pkg::rsp_type rsp_word,
   output int               mismatch_count,
   output int               owed_count
);
   import stt_pkg::*;

   bit             slot_armed [SLOTS];
   slot_entry_type slot_state [SLOTS];
   rsp_type        owed_answers [$];
   int             fault_tally;

   initial begin
      mismatch_count = 0;
      owed_count     = 0;
      fault_tally    = 0;
   end

   function automatic rsp_type answer(logic [1:0] kind, logic [1:0] status,
                                      logic [15:0] key, int idx, logic last);
      rsp_type w;
      w.kind       = kind;
      w.status     = status;
      w.fired_key  = key;
      w.slot_index = 4'(idx);
      w.last       = last;
      return w;
   endfunction

   function automatic int slot_of_owner(logic [15:0] key);
      int i;
      for (i = 0; i < SLOTS; i++)
         if (slot_armed[i] && slot_state[i].owner == key)
            return i;
      return -1;
   endfunction

   // Applies one request to the table copy and queues the answers it owes.
   task automatic apply_request(input req_type w);
      int          i;
      int          hit;
      int          free_idx;
      rsp_type     held;
      bit          have_held;
      logic [31:0] lag;
      have_held = 1'b0;
      case (w.operation)
         OP_CREATE: begin
            hit      = slot_of_owner(w.owner_key);
            free_idx = -1;
            for (i = SLOTS - 1; i >= 0; i--)
               if (!slot_armed[i])
                  free_idx = i;
            if (w.owner_key == '0) begin
               owed_answers.push_back(answer(KIND_CREATE, STAT_NULL_KEY, w.owner_key, 0, 1'b1));
            end else if (hit >= 0) begin
               owed_answers.push_back(answer(KIND_CREATE, STAT_DUPLICATE, w.owner_key, 0, 1'b1));
            end else if (free_idx < 0) begin
               owed_answers.push_back(answer(KIND_CREATE, STAT_FULL, w.owner_key, 0, 1'b1));
            end else begin
               slot_armed[free_idx]         = 1'b1;
               slot_state[free_idx].owner   = w.owner_key;
               slot_state[free_idx].period  = w.interval_ms;
               slot_state[free_idx].expiry  = w.now_ms + w.interval_ms;
               slot_state[free_idx].repeats = w.repeat_count;
               owed_answers.push_back(answer(KIND_CREATE, STAT_OK, w.owner_key, free_idx, 1'b1));
            end
         end
         OP_CANCEL: begin
            hit = slot_of_owner(w.owner_key);
            if (w.owner_key == '0) begin
               owed_answers.push_back(answer(KIND_CANCEL, STAT_NULL_KEY, w.owner_key, 0, 1'b1));
            end else if (hit < 0) begin
               owed_answers.push_back(answer(KIND_CANCEL, STAT_NOT_FOUND, w.owner_key, 0, 1'b1));
            end else begin
               slot_armed[hit] = 1'b0;
               owed_answers.push_back(answer(KIND_CANCEL, STAT_REMOVED, w.owner_key, hit, 1'b1));
            end
         end
         OP_TICK: begin
            // Each fire word is held back one step so that the final one can
            // be marked as last once the sweep is over.
            for (i = 0; i < SLOTS; i++) begin
               lag = w.now_ms - slot_state[i].expiry;
               if (slot_armed[i] && !lag[31]) begin
                  if (have_held)
                     owed_answers.push_back(held);
                  held      = answer(KIND_FIRE, STAT_OK, slot_state[i].owner, i, 1'b0);
                  have_held = 1'b1;
                  if (slot_state[i].repeats == 1) begin
                     slot_armed[i] = 1'b0;
                  end else begin
                     if (slot_state[i].repeats > 1)
                        slot_state[i].repeats = slot_state[i].repeats - 1;
                     slot_state[i].expiry = slot_state[i].expiry + slot_state[i].period;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               owed_answers.push_back(held);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic compare_answer(input rsp_type got);
      rsp_type want;
      if (owed_answers.size() == 0) begin
         $display("%0t: answer word with none owed: kind=%0d status=%0d key=%h slot=%0d last=%0b",
                  $time, got.kind, got.status, got.fired_key, got.slot_index, got.last);
         fault_tally++;
      end else begin
         want = owed_answers.pop_front();
         if (got.kind !== want.kind || got.status !== want.status ||
             got.fired_key !== want.fired_key || got.slot_index !== want.slot_index ||
             got.last !== want.last) begin
            $display("%0t: answer mismatch: expected kind=%0d status=%0d key=%h slot=%0d last=%0b, actual kind=%0d status=%0d key=%h slot=%0d last=%0b",
                     $time, want.kind, want.status, want.fired_key, want.slot_index,
                     want.last, got.kind, got.status, got.fired_key, got.slot_index,
                     got.last);
            fault_tally++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++)
            slot_armed[i] = 1'b0;
         owed_answers.delete();
      end else begin
         // Answers are checked before the new request is applied, so that a
         // stray answer is never matched against words that were just owed.
         if (rsp_valid && !rsp_stall)
            compare_answer(rsp_word);
         if (req_valid && !req_stall)
            apply_request(req_word);
      end
      mismatch_count <= fault_tally;
      owed_count     <= owed_answers.size();
   end

endmodule

// ===== dv/software_timer_slot_table_unit_tb.sv =====
`timescale 1ns / 1ps

// Top of the timer slot table bench. It makes the requests, randomly idles
// the sender and stalls the receiver, and gives the verdict. Prediction and
// comparison live in the checker that sits beside the block.
module software_timer_slot_table_unit_tb;
   import stt_pkg::*;

   localparam int SLOT_COUNT  = SLOT_COUNT_DEF;
   // The slowest correct run stays far below this, even if every request
   // caused sixteen fire words and every word waited out a long stall.
   localparam int CYCLE_LIMIT = 1000000;
   // Once nothing is owed, this many cycles pass so that a stray late word
   // from the block would still be seen by the checker.
   localparam int TAIL_CYCLES = 2 * SLOT_COUNT + 4;
   localparam int PHASE_ITEMS = 48;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   int          mismatch_count;
   int          owed_count;
   int          cycle_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   logic [31:0] wall_ms = '0;

   // The clock runs at a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   software_timer_slot_table_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   software_timer_slot_table_unit_checker #(.SLOTS(SLOT_COUNT)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .owed_count     (owed_count)
   );

   // The receiver decides each cycle, at the falling edge, whether it holds
   // off the answer channel. The chance is set per phase of the run.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // A hung block or a lost answer ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic req_type make_request(logic [1:0] op, logic [15:0] key,
                                            logic [31:0] span, logic [31:0] count,
                                            logic [31:0] at_ms);
      req_type w;
      w.operation    = op;
      w.owner_key    = key;
      w.interval_ms  = span;
      w.repeat_count = count;
      w.now_ms       = at_ms;
      return w;
   endfunction

   // Offers one request word and returns at the falling edge after the
   // block took it. It is always entered at a falling edge. Before the word
   // goes out the sender may sit idle for a random number of cycles; when it
   // does not, valid simply stays high from the previous word.
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Draws one random request. Keys mostly come from a small pool, so that
   // duplicates, successful cancels and a full table all happen often. The
   // millisecond clock mostly creeps forward, so that timers set here expire
   // on later ticks, and now and then jumps anywhere in its range.
   task automatic draw_request(output req_type w);
      int unsigned pick;
      logic [1:0]  op;
      logic [15:0] key;
      logic [31:0] span;
      logic [31:0] count;
      pick = $urandom_range(99);
      if (pick < 5)
         wall_ms = $urandom();
      else
         wall_ms = wall_ms + $urandom_range(0, 6);

      pick = $urandom_range(99);
      if (pick < 40)
         op = OP_CREATE;
      else if (pick < 60)
         op = OP_CANCEL;
      else if (pick < 95)
         op = OP_TICK;
      else
         op = OP_NONE;

      pick = $urandom_range(99);
      if (pick < 6)
         key = '0;
      else if (pick < 86)
         key = 16'($urandom_range(1, 20));
      else
         key = 16'($urandom_range(0, 65535));

      pick = $urandom_range(99);
      if (pick < 60)
         span = $urandom_range(0, 12);
      else if (pick < 75)
         span = '0;
      else if (pick < 90)
         span = $urandom_range(13, 200);
      else
         span = $urandom();

      // Counts of one fire once, small counts count down, zero and negative
      // counts repeat until cancelled.
      pick = $urandom_range(99);
      if (pick < 35)
         count = 32'd1;
      else if (pick < 60)
         count = $urandom_range(2, 4);
      else if (pick < 75)
         count = '0;
      else if (pick < 85)
         count = 32'd0 - $urandom_range(1, 5);
      else
         count = $urandom();

      w = make_request(op, key, span, count, wall_ms);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
      req_type w;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (items) begin
         draw_request(w);
         send_word(w);
      end
   endtask

   initial begin
      // Synchronous reset is held high from the start and dropped at a
      // falling edge; it is never raised again.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening, sent with no idling on either side.
      // A tick on an empty table owes nothing at all.
      send_word(make_request(OP_TICK, 16'h0000, 32'd0, 32'd0, 32'd0));
      // Key zero is refused by both create and cancel.
      send_word(make_request(OP_CREATE, 16'h0000, 32'd5, 32'd1, 32'd0));
      send_word(make_request(OP_CANCEL, 16'h0000, 32'd0, 32'd0, 32'd0));
      // Cancel of a key that was never armed.
      send_word(make_request(OP_CANCEL, 16'h1234, 32'd0, 32'd0, 32'd0));
      // The unused operation code with every field bit set is dropped.
      send_word(make_request(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // Largest key, interval and count at the top of time, so the expiry
      // wraps; the same key a second time is a duplicate.
      send_word(make_request(OP_CREATE, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_request(OP_CREATE, 16'hFFFF, 32'd3, 32'd1, 32'd0));
      // A zero interval that repeats forever fires on every tick from now on.
      send_word(make_request(OP_CREATE, 16'h0001, 32'd0, 32'd0, 32'd1000));
      // A one-shot timer, and one with the most negative count.
      send_word(make_request(OP_CREATE, 16'h0002, 32'd5, 32'd1, 32'd1000));
      send_word(make_request(OP_CREATE, 16'h0004, 32'd7, 32'h8000_0000, 32'd1000));
      // One millisecond short of the zero-interval expiry, then past all.
      send_word(make_request(OP_TICK, 16'h0000, 32'd0, 32'd0, 32'd999));
      send_word(make_request(OP_TICK, 16'h0000, 32'd0, 32'd0, 32'd1010));
      send_word(make_request(OP_CANCEL, 16'h0004, 32'd0, 32'd0, 32'd0));
      send_word(make_request(OP_CANCEL, 16'h0004, 32'd0, 32'd0, 32'd0));
      // Fill every free slot with due two-shot timers, then one more create
      // finds the table full, and a single tick fires all sixteen slots.
      for (int k = 0; k < SLOT_COUNT - 1; k++)
         send_word(make_request(OP_CREATE, 16'h0100 + 16'(k), 32'd0, 32'd2, 32'd1010));
      send_word(make_request(OP_TICK, 16'h0000, 32'd0, 32'd0, 32'd1010));

      // Random part: first without any idling, then a mostly idle sender,
      // then a mostly stalling receiver, then light idling on both sides.
      // The clock starts just below the wrap point so ticks cross it soon.
      wall_ms = 32'hFFFF_FF80;
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(87, 0, PHASE_ITEMS);
      run_phase(0, 87, PHASE_ITEMS);
      run_phase(7, 7, PHASE_ITEMS);
      req_valid <= 1'b0;

      // Drain every owed answer, then give the block time to show any word
      // it should not send. The cycle limit bounds both waits.
      @(posedge clock);
      while (owed_count != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (owed_count != 0)
         $display("%0t: %0d answer words never arrived", $time, owed_count);
      if (mismatch_count == 0 && owed_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
